@@ design/lirs_pkg.sv @@
// Shared constants and controller/datapath interface types for the resampler.
`default_nettype none
package lirs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int COUNT_BITS  = 32;
  localparam int PHASE_BITS  = COUNT_BITS + FRAC_BITS;
  localparam int STEP_BITS   = 21;
  localparam int CHAN_BITS   = 2;
  localparam int RESULT_CAP  = 34;
  localparam int NUM_BITS    = 6;
  localparam int IDX_BITS    = 2;
  localparam int DATA_BITS   = 32;
  localparam int PROD_BITS   = 2 * (SAMPLE_BITS + 1);

  localparam logic [IDX_BITS-1:0] CFG_PHASE_STEP    = 2'd0;
  localparam logic [IDX_BITS-1:0] CFG_OUTPUT_FRAMES = 2'd1;
  localparam logic [IDX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam logic [STEP_BITS-1:0]  STEP_RESET  = 21'd65536;
  localparam logic [CHAN_BITS-1:0]  CHAN_RESET  = 2'd2;

  typedef struct packed {
    logic load_in;  // capture input word, start a new item
    logic push;     // move pending result into the output register
    logic last;     // pushed result closes the item
    logic rep;      // build a repeat result from the current frame
    logic mul;      // register interpolation products
    logic add;      // finish interpolated result, advance phase
    logic finish;   // update held frame and counters, item done
  } lirs_cmd_t;

  typedef struct packed {
    logic cond_lerp;
    logic cond_rep;
    logic have_pend;
    logic out_free;
  } lirs_stat_t;

endpackage
`default_nettype wire

@@ design/lirs_ctrl.sv @@
// Controller state machine sequencing interpolation and repeat results.
`default_nettype none
module lirs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  output lirs_pkg::lirs_cmd_t      cmd,
  input  wire lirs_pkg::lirs_stat_t stat
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_ADD   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   done;
  logic   stall;

  assign in_tready = (state_r == ST_IDLE);
  assign done      = !stat.cond_lerp && !stat.cond_rep;
  assign stall     = stat.have_pend && !stat.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!stall) begin
          cmd.push = stat.have_pend;
          cmd.last = done;
          priority if (stat.cond_lerp) begin
            state_nxt = ST_MUL;
          end else if (stat.cond_rep) begin
            cmd.rep = 1'b1;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_CHECK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/lirs_dp.sv @@
// Datapath: registers, phase accumulator, interpolation and output register.
`default_nettype none
module lirs_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire lirs_pkg::lirs_cmd_t                 cmd,
  output lirs_pkg::lirs_stat_t                     stat,
  input  wire logic                                cfg_valid,
  input  wire logic [lirs_pkg::IDX_BITS-1:0]       cfg_index,
  input  wire logic [lirs_pkg::DATA_BITS-1:0]      cfg_data,
  input  wire logic signed [lirs_pkg::SAMPLE_BITS-1:0] in_left,
  input  wire logic signed [lirs_pkg::SAMPLE_BITS-1:0] in_right,
  input  wire logic                                in_final,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [lirs_pkg::SAMPLE_BITS-1:0]  out_left,
  output logic signed [lirs_pkg::SAMPLE_BITS-1:0]  out_right,
  output logic                                     out_run_end,
  output logic                                     out_stream_end
);

  localparam int SB = lirs_pkg::SAMPLE_BITS;
  localparam int FB = lirs_pkg::FRAC_BITS;
  localparam int CB = lirs_pkg::COUNT_BITS;
  localparam int PB = lirs_pkg::PHASE_BITS;
  localparam int XB = lirs_pkg::PROD_BITS;

  // configuration
  logic [lirs_pkg::STEP_BITS-1:0] step_r;
  logic [CB-1:0]                  total_r;
  logic [lirs_pkg::CHAN_BITS-1:0] chan_r;
  logic                           stereo;

  // item and sound state
  logic signed [SB-1:0] cur_l_r, cur_r_r, held_l_r, held_r_r;
  logic                 fin_r;
  logic [PB-1:0]        phase_r;
  logic [CB-1:0]        seen_r, fout_r, fout_inc;
  logic [lirs_pkg::NUM_BITS-1:0] n_r;

  // interpolation
  logic signed [SB:0]   diff_l, diff_r, frac_s;
  logic signed [XB-1:0] prod_l_r, prod_r_r;
  logic signed [SB+1:0] sum_l, sum_r;

  // pending result
  logic                 have_pend_r, pend_send_r;
  logic signed [SB-1:0] pend_l_r, pend_r_r;

  // output register
  logic                 out_valid_r, out_last_r, out_send_r;
  logic signed [SB-1:0] out_l_r, out_r_r;

  logic cnt_ok;

  assign stereo   = chan_r[1];
  assign fout_inc = fout_r + 1'b1;
  assign cnt_ok   = (n_r < lirs_pkg::NUM_BITS'(lirs_pkg::RESULT_CAP)) && (fout_r < total_r);

  assign stat.cond_lerp = (seen_r != '0) && cnt_ok && (phase_r[PB-1:FB] < seen_r);
  assign stat.cond_rep  = fin_r && cnt_ok;
  assign stat.have_pend = have_pend_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign diff_l = {cur_l_r[SB-1], cur_l_r} - {held_l_r[SB-1], held_l_r};
  assign diff_r = {cur_r_r[SB-1], cur_r_r} - {held_r_r[SB-1], held_r_r};
  assign frac_s = {1'b0, phase_r[FB-1:0]};
  assign sum_l  = {{2{held_l_r[SB-1]}}, held_l_r} + prod_l_r[XB-1:FB];
  assign sum_r  = {{2{held_r_r[SB-1]}}, held_r_r} + prod_r_r[XB-1:FB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= lirs_pkg::STEP_RESET;
      total_r <= '0;
      chan_r  <= lirs_pkg::CHAN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lirs_pkg::CFG_PHASE_STEP:    step_r  <= cfg_data[lirs_pkg::STEP_BITS-1:0];
        lirs_pkg::CFG_OUTPUT_FRAMES: total_r <= cfg_data[CB-1:0];
        lirs_pkg::CFG_CHANNEL_COUNT: chan_r  <= cfg_data[lirs_pkg::CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_l_r <= in_left;
      cur_r_r <= stereo ? in_right : '0;
      fin_r   <= in_final;
    end
    if (cmd.mul) begin
      prod_l_r <= diff_l * frac_s;
      prod_r_r <= diff_r * frac_s;
    end
    if (cmd.add) begin
      pend_l_r    <= sum_l[SB-1:0];
      pend_r_r    <= stereo ? sum_r[SB-1:0] : '0;
      pend_send_r <= (fout_inc == total_r);
    end else if (cmd.rep) begin
      pend_l_r    <= cur_l_r;
      pend_r_r    <= cur_r_r;
      pend_send_r <= (fout_inc == total_r);
    end
    if (cmd.push) begin
      out_l_r    <= pend_l_r;
      out_r_r    <= pend_r_r;
      out_last_r <= cmd.last;
      out_send_r <= pend_send_r || (cmd.last && fin_r);
    end
  end

  // control and sound state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_l_r    <= '0;
      held_r_r    <= '0;
      phase_r     <= '0;
      seen_r      <= '0;
      fout_r      <= '0;
      n_r         <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        n_r <= '0;
      end
      if (cmd.add || cmd.rep) begin
        fout_r <= fout_inc;
        n_r    <= n_r + 1'b1;
      end
      if (cmd.add) begin
        phase_r <= phase_r + PB'(step_r);
      end
      priority if (cmd.add || cmd.rep) begin
        have_pend_r <= 1'b1;
      end else if (cmd.push || cmd.load_in) begin
        have_pend_r <= 1'b0;
      end else begin
        have_pend_r <= have_pend_r;
      end
      if (cmd.finish) begin
        if (fin_r) begin
          held_l_r <= '0;
          held_r_r <= '0;
          phase_r  <= '0;
          seen_r   <= '0;
          fout_r   <= '0;
        end else begin
          held_l_r <= cur_l_r;
          held_r_r <= cur_r_r;
          seen_r   <= seen_r + 1'b1;
        end
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left       = out_l_r;
  assign out_right      = out_r_r;
  assign out_run_end    = out_last_r;
  assign out_stream_end = out_send_r;

endmodule
`default_nettype wire

@@ design/linear_interp_resampler_core.sv @@
// Top level of the linear interpolation sample rate converter.
//
//  channel  | direction | handshake               | payload
//  in_      | slave     | in_tvalid / in_tready   | tdata {right,left}, tlast final frame
//  out_     | master    | out_tvalid / out_tready | tdata {right,left}, tlast run end,
//           |           |                         | tuser stream end
//  cfg_     | slave     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A word is accepted in IDLE and closed in CHECK. Each interpolated result takes a
// multiply (shared pair of 17x17 multipliers) then an add; a repeat is built in CHECK.
// Results leave through a single output register; a full register stalls the
// sequencer. rst_n is synchronous; config resets to step 1.0, zero frames, stereo.
// cfg_ready is always high.
`default_nettype none
module linear_interp_resampler_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] sample_left, [31:16] sample_right
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] out_left, [31:16] out_right
  output logic             out_tlast,
  output logic             out_tuser,  // [0] stream_end
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [lirs_pkg::IDX_BITS-1:0]  cfg_index,
  input  wire logic [lirs_pkg::DATA_BITS-1:0] cfg_data
);

  localparam int SB = lirs_pkg::SAMPLE_BITS;

  lirs_pkg::lirs_cmd_t  cmd;
  lirs_pkg::lirs_stat_t stat;
  logic signed [SB-1:0] res_l, res_r;

  assign cfg_ready = 1'b1;

  lirs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  lirs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_left        (in_tdata[SB-1:0]),
    .in_right       (in_tdata[2*SB-1:SB]),
    .in_final       (in_tlast),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_left       (res_l),
    .out_right      (res_r),
    .out_run_end    (out_tlast),
    .out_stream_end (out_tuser)
  );

  assign out_tdata = {res_r, res_l};

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> stat.out_free)
    else $error("result pushed into a full output register");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again before the word was processed");

  a_stream_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("stream end on a result that does not close its word");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for linear_interp_resampler_core: predicts every output word and compares.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lirs_pkg::IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } pcm_frame_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        run_end;
    logic        stream_end;
  } pcm_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [lirs_pkg::IDX_BITS-1:0]  cfg_index = '0;
  logic [lirs_pkg::DATA_BITS-1:0] cfg_data = '0;

  linear_interp_resampler_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // resampler shadow state
  logic [lirs_pkg::STEP_BITS-1:0]  step_reg  = lirs_pkg::STEP_RESET;
  logic [lirs_pkg::COUNT_BITS-1:0] total_reg = '0;
  logic [lirs_pkg::CHAN_BITS-1:0]  chan_reg  = lirs_pkg::CHAN_RESET;
  logic [lirs_pkg::PHASE_BITS-1:0] acc_phase = '0;
  logic [lirs_pkg::COUNT_BITS-1:0] in_count  = '0;
  logic [lirs_pkg::COUNT_BITS-1:0] out_count = '0;
  longint prev_left  = 0;
  longint prev_right = 0;

  pcm_frame_t  frames_to_send[$];
  pcm_result_t expected_results[$];
  int frames_queued = 0;
  int frames_fed = 0;
  int errors = 0;

  function automatic logic [15:0] lerp16(input longint a, input longint b, input longint fr);
    longint prod;
    longint sum;
    prod = (b - a) * fr;
    sum = a + (prod >>> lirs_pkg::FRAC_BITS);
    return sum[15:0];
  endfunction

  task automatic resample_frame(input pcm_frame_t f);
    pcm_result_t burst [lirs_pkg::RESULT_CAP];
    logic   stereo;
    longint cur_l;
    longint cur_r;
    longint fr;
    int     n;
    stereo = (chan_reg >= 2);
    cur_l = $signed(f.left);
    cur_r = 0;
    if (stereo) cur_r = $signed(f.right);
    n = 0;
    if (in_count != 0) begin
      while (n < lirs_pkg::RESULT_CAP && out_count < total_reg &&
             (acc_phase >> lirs_pkg::FRAC_BITS) < in_count) begin
        fr = acc_phase[lirs_pkg::FRAC_BITS-1:0];
        out_count = out_count + 1'b1;
        burst[n].left = lerp16(prev_left, cur_l, fr);
        burst[n].right = stereo ? lerp16(prev_right, cur_r, fr) : 16'h0;
        burst[n].run_end = 1'b0;
        burst[n].stream_end = (out_count == total_reg);
        n++;
        acc_phase = acc_phase + step_reg;
      end
    end
    if (f.last) begin
      while (n < lirs_pkg::RESULT_CAP && out_count < total_reg) begin
        out_count = out_count + 1'b1;
        burst[n].left = cur_l[15:0];
        burst[n].right = cur_r[15:0];
        burst[n].run_end = 1'b0;
        burst[n].stream_end = (out_count == total_reg);
        n++;
      end
      if (n > 0) burst[n-1].stream_end = 1'b1;
      acc_phase = '0;
      prev_left = 0;
      prev_right = 0;
      in_count = '0;
      out_count = '0;
    end else begin
      prev_left = cur_l;
      prev_right = cur_r;
      in_count = in_count + 1'b1;
    end
    if (n > 0) burst[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(burst[i]);
  endtask

  function automatic int next_gap(inout bit calm);
    if ($urandom_range(0, 24) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // input side
  pcm_frame_t feed_frame;
  bit feed_fire;
  bit feed_calm = 1'b0;
  int feed_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      feed_gap = 0;
    end else begin
      feed_fire = in_tvalid && in_tready;
      if (feed_fire) begin
        resample_frame(feed_frame);
        frames_fed++;
      end
      if (!in_tvalid || feed_fire) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_tvalid <= 1'b0;
        end else if (frames_to_send.size() != 0) begin
          feed_frame = frames_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {feed_frame.right, feed_frame.left};
          in_tlast <= feed_frame.last;
          feed_gap = next_gap(feed_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  pcm_result_t got;
  pcm_result_t want;
  bit drain_calm = 1'b0;
  int drain_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      drain_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.left = out_tdata[15:0];
        got.right = out_tdata[31:16];
        got.run_end = out_tlast;
        got.stream_end = out_tuser;
        if (expected_results.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected word left %h right %h last %b end %b",
                     $realtime, got.left, got.right, got.run_end, got.stream_end);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("%0t: mismatch exp left %h right %h last %b end %b, got %h %h %b %b",
                       $realtime, want.left, want.right, want.run_end, want.stream_end,
                       got.left, got.right, got.run_end, got.stream_end);
            errors++;
          end
        end
        drain_gap = next_gap(drain_calm);
      end
      if (drain_gap > 0) begin
        drain_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (frames_fed != frames_queued || expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lirs_pkg::IDX_BITS-1:0] idx,
                           input logic [lirs_pkg::DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      lirs_pkg::CFG_PHASE_STEP:    step_reg = val[lirs_pkg::STEP_BITS-1:0];
      lirs_pkg::CFG_OUTPUT_FRAMES: total_reg = val[lirs_pkg::COUNT_BITS-1:0];
      lirs_pkg::CFG_CHANNEL_COUNT: chan_reg = val[lirs_pkg::CHAN_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] step_w, input logic [31:0] total_w,
                           input logic [31:0] chan_w, input bit spare);
    wait_drained();
    write_reg(lirs_pkg::CFG_PHASE_STEP, step_w);
    write_reg(lirs_pkg::CFG_OUTPUT_FRAMES, total_w);
    write_reg(lirs_pkg::CFG_CHANNEL_COUNT, chan_w);
    if (spare) write_reg(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_frame(input logic [15:0] l, input logic [15:0] r, input logic fin);
    pcm_frame_t f;
    f.left = l;
    f.right = r;
    f.last = fin;
    frames_to_send.push_back(f);
    frames_queued++;
  endtask

  function automatic logic [15:0] pick_sample();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    return 16'($urandom);
  endfunction

  task automatic queue_sound(input int len, input bit ends);
    for (int i = 0; i < len; i++)
      queue_frame(pick_sample(), pick_sample(), ends && (i == len - 1));
  endtask

  initial begin : stimulus
    logic [lirs_pkg::STEP_BITS-1:0] step_val;
    logic [lirs_pkg::CHAN_BITS-1:0] chan_val;
    logic [31:0] step_w;
    logic [31:0] chan_w;
    longint unsigned tot;
    int n_frames;
    int len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // upsampling between full-scale extremes, then a one-frame sound
    configure(32'd24576, 32'd10, 32'd2, 1'b0);
    queue_frame(16'h7fff, 16'h8000, 1'b0);
    queue_frame(16'h8000, 16'h7fff, 1'b0);
    queue_frame(16'h0000, 16'hffff, 1'b0);
    queue_frame(16'hffff, 16'h0001, 1'b1);
    queue_frame(16'h1234, 16'hedcb, 1'b1);

    // mono decimation, right channel must be ignored
    configure(32'd1048576, 32'd2, 32'd1, 1'b1);
    queue_frame(16'h4000, 16'h7fff, 1'b0);
    queue_frame(16'hc000, 16'h8000, 1'b0);
    queue_frame(16'h0001, 16'h5555, 1'b0);
    queue_frame(16'h8001, 16'haaaa, 1'b0);
    queue_frame(16'h7ffe, 16'h0f0f, 1'b1);

    // zero step: phase stuck, result cap on every frame after the first, leftovers dropped
    configure(32'd0, 32'd80, 32'd3, 1'b1);
    queue_frame(16'h0100, 16'hff00, 1'b0);
    queue_frame(16'h8000, 16'h7fff, 1'b0);
    queue_frame(16'h7fff, 16'h8000, 1'b1);

    // output count reached before the final frame
    configure(32'd16384, 32'd3, 32'd2, 1'b0);
    queue_frame(16'h0000, 16'h0000, 1'b0);
    queue_frame(16'h7fff, 16'h8000, 1'b0);
    queue_frame(16'h1111, 16'h2222, 1'b0);
    queue_frame(16'h3333, 16'h4444, 1'b0);
    queue_frame(16'h5555, 16'h6666, 1'b1);

    // max step and count, channel code zero with junk in upper data bits
    configure(32'hffff_ffff, 32'hffff_ffff, 32'hffff_fffc, 1'b0);
    queue_frame(16'h8000, 16'h7fff, 1'b0);
    queue_frame(16'h7fff, 16'h8000, 1'b0);
    queue_frame(16'hfffe, 16'h0002, 1'b1);

    while (frames_queued < 460) begin
      case ($urandom_range(0, 9))
        0: step_val = 21'd4096;
        1: step_val = 21'd1048576;
        2: step_val = 21'($urandom_range(0, 4095));
        3: step_val = 21'($urandom_range(1048577, 2097151));
        4, 5, 6: step_val = 21'($urandom_range(4096, 65536));
        default: step_val = 21'($urandom_range(65537, 1048576));
      endcase
      n_frames = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 10);
      if (step_val == 0) tot = $urandom_range(0, 100);
      else tot = (longint'(n_frames) << 16) / step_val;
      case ($urandom_range(0, 9))
        7: tot = tot + $urandom_range(1, 3);
        8: tot = (tot > 2) ? tot - $urandom_range(1, 2) : 0;
        9: tot = $urandom_range(0, 1) ? 0 : {1'b1, 31'($urandom)};
        default: ;
      endcase
      if (tot > 64'hffff_ffff) tot = 64'hffff_ffff;
      if ($urandom_range(0, 4) != 0) chan_val = 2'($urandom_range(1, 2));
      else chan_val = $urandom_range(0, 1) ? 2'd3 : 2'd0;
      step_w = {11'd0, step_val};
      chan_w = {30'd0, chan_val};
      if ($urandom_range(0, 3) == 0) step_w[31:21] = 11'($urandom);
      if ($urandom_range(0, 3) == 0) chan_w[31:2] = 30'($urandom);
      configure(step_w, tot[31:0], chan_w, $urandom_range(0, 9) == 0);
      repeat ($urandom_range(1, 3)) begin
        len = n_frames - 1 + $urandom_range(0, 2);
        if (len == 0) len = 1;
        queue_sound(len, $urandom_range(0, 9) != 0);
      end
    end

    wait_drained();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
